FILE: src/bbc_pkg.sv
// Package with shared types, character codes and the bracket classifier.
package bbc_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_COUNT_WIDTH = 16;

    // Bracket characters.
    localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;

    // Bracket kind as held on the stack.
    typedef enum logic [1:0] {
        BK_ROUND  = 2'd0,
        BK_CURLY  = 2'd1,
        BK_SQUARE = 2'd2,
        BK_ANGLE  = 2'd3
    } t_bkind;

    // Error codes reported with each verdict.
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_EMPTY_CLOSE = 3'd1,
        ERR_MISMATCH    = 3'd2,
        ERR_UNCLOSED    = 3'd3,
        ERR_OVERFLOW    = 3'd4
    } t_err;

    // Result of classifying one byte.
    typedef struct packed {
        logic   is_open;
        logic   is_close;
        t_bkind kind;
    } t_bclass;

    // Command from the control logic to the stack.
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        t_bkind kind;
    } t_stack_cmd;

    // Decode a byte into open/close flags and a bracket kind.
    function automatic t_bclass classify(input logic [7:0] c);
        t_bclass r;
        r = '{is_open: 1'b0, is_close: 1'b0, kind: BK_ROUND};
        case (c)
            CH_ROUND_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: BK_ROUND};
            CH_CURLY_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: BK_CURLY};
            CH_SQUARE_OPEN:  r = '{is_open: 1'b1, is_close: 1'b0, kind: BK_SQUARE};
            CH_ANGLE_OPEN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: BK_ANGLE};
            CH_ROUND_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: BK_ROUND};
            CH_CURLY_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: BK_CURLY};
            CH_SQUARE_CLOSE: r = '{is_open: 1'b0, is_close: 1'b1, kind: BK_SQUARE};
            CH_ANGLE_CLOSE:  r = '{is_open: 1'b0, is_close: 1'b1, kind: BK_ANGLE};
            default:         r = '{is_open: 1'b0, is_close: 1'b0, kind: BK_ROUND};
        endcase
        return r;
    endfunction

endpackage

FILE: src/bbc_stack.sv
// Bracket stack: top entry in a register, the rest in a memory with a prefetched next entry.
module bbc_stack
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    localparam int LW = $clog2(STACK_DEPTH + 1),
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stack_cmd    i_cmd,
    output logic [LW-1:0] o_level,
    output t_bkind        o_top
);

    t_bkind        mem [STACK_DEPTH];
    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    t_bkind        r_top;
    t_bkind        n_top;
    t_bkind        r_rd;
    logic          r_byp;
    t_bkind        r_byp_val;
    t_bkind        w_below;
    logic [LW-1:0] w_lvl_m1;
    logic [LW-1:0] w_lvl_m2;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    // The entry under the top: the old top right after a push, else the memory read.
    assign w_below = r_byp ? r_byp_val : r_rd;

    // Next level and next top.
    always_comb begin
        n_level = r_level;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_level = '0;
        end else if (i_cmd.push) begin
            n_level = r_level + LW'(1);
            n_top   = i_cmd.kind;
        end else if (i_cmd.pop) begin
            n_level = r_level - LW'(1);
            n_top   = w_below;
        end
    end

    // On a push the old top moves into the memory at level - 1.
    assign w_lvl_m1  = r_level - LW'(1);
    assign w_wr_addr = w_lvl_m1[AW-1:0];

    // Prefetch the entry that will sit under the top after this cycle.
    assign w_lvl_m2  = (n_level >= LW'(2)) ? (n_level - LW'(2)) : '0;
    assign w_rd_addr = w_lvl_m2[AW-1:0];

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear && r_level != '0) begin
            mem[w_wr_addr] <= r_top;
        end
        r_rd <= mem[w_rd_addr];
    end

    // Top entry and the bypass value for a read that follows a push.
    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_byp_val <= r_top;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_level <= n_level;
            r_byp   <= i_cmd.push && !i_cmd.clear;
        end
    end

    assign o_level = r_level;
    assign o_top   = r_top;

endmodule

FILE: src/bracket_balance_checker_unit.sv
// Top level of the balanced-bracket checker for a byte stream.
//
// The block takes one byte per clock cycle and keeps a stack of open bracket kinds
// for (), {}, [] and <>; every byte is processed in the cycle in which it is
// transferred, and the verdict for a string appears on the output port in the cycle
// after its last byte is transferred, held until it is taken. The stack keeps its
// top entry in a register and the entries below it in a memory with one write and
// one registered read per cycle; the entry under the top is always prefetched, so
// pushes and pops can follow each other in every cycle. The input side is stalled
// only while a verdict waits and the output side is stalled.
module bracket_balance_checker_unit
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_char_code,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_balanced,
    output logic [2:0]             o_error_kind,
    output logic [COUNT_WIDTH-1:0] o_pair_count
);

    localparam int LW = $clog2(STACK_DEPTH + 1);

    logic                   w_accept;
    t_bclass                w_cls;
    t_stack_cmd             w_cmd;
    logic [LW-1:0]          w_level;
    logic [LW-1:0]          w_level_after;
    t_bkind                 w_top;
    t_err                   r_err;
    t_err                   n_err;
    t_err                   w_verdict;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic                   r_out_valid;
    logic                   r_out_balanced;
    t_err                   r_out_err;
    logic [COUNT_WIDTH-1:0] r_out_cnt;

    // A new byte is taken unless a verdict is waiting on a stalled output.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cls      = classify(i_char_code);

    // Per-byte decision: push, pop, count or record the first error.
    always_comb begin
        w_cmd         = '{push: 1'b0, pop: 1'b0, clear: 1'b0, kind: w_cls.kind};
        n_err         = r_err;
        n_cnt         = r_cnt;
        w_level_after = w_level;
        if (w_accept && r_err == ERR_NONE) begin
            if (w_cls.is_open) begin
                if (w_level == LW'(STACK_DEPTH)) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    w_cmd.push    = 1'b1;
                    w_level_after = w_level + LW'(1);
                end
            end else if (w_cls.is_close) begin
                if (w_level == '0) begin
                    n_err = ERR_EMPTY_CLOSE;
                end else if (w_top != w_cls.kind) begin
                    n_err = ERR_MISMATCH;
                end else begin
                    w_cmd.pop     = 1'b1;
                    w_level_after = w_level - LW'(1);
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + COUNT_WIDTH'(1);
                    end
                end
            end
        end
        w_cmd.clear = w_accept && i_last;
    end

    // Verdict for the string ending with this byte.
    assign w_verdict = (n_err == ERR_NONE && w_level_after != '0) ? ERR_UNCLOSED : n_err;

    bbc_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_level(w_level),
        .o_top  (w_top)
    );

    // Per-string error and pair count; cleared after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= ERR_NONE;
            r_cnt <= '0;
        end else if (w_accept && i_last) begin
            r_err <= ERR_NONE;
            r_cnt <= '0;
        end else begin
            r_err <= n_err;
            r_cnt <= n_cnt;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            r_out_balanced <= (w_verdict == ERR_NONE);
            r_out_err      <= w_verdict;
            r_out_cnt      <= n_cnt;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_balanced   = r_out_balanced;
    assign o_error_kind = r_out_err;
    assign o_pair_count = r_out_cnt;

    // The stack never holds more than its depth.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // A transferred last byte always produces a verdict in the next cycle.
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> o_out_valid)
        else $error("missing verdict after last byte");

    // Once an error is recorded the stack stays frozen until the string ends.
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !(w_accept && i_last)) |=> $stable(w_level))
        else $error("stack moved after an error");

    // A balanced verdict carries no error code.
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_balanced) |-> (o_error_kind == ERR_NONE))
        else $error("balanced verdict with an error code");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the bracket balance checker: directed strings, full and overflowing stacks and random strings.
module tb_top;
    import bbc_pkg::*;

    localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
    localparam int COUNT_WIDTH  = DEF_COUNT_WIDTH;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_CYCLES  = 200;

    // One verdict as the block reports it.
    typedef struct packed {
        logic                   balanced;
        t_err                   kind;
        logic [COUNT_WIDTH-1:0] pairs;
    } t_verdict;

    // One row of the directed stimulus; the verdict is typed in where given is set.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       given;
        t_verdict   want;
    } t_row;

    // How one byte acts on the stack.
    typedef struct packed {
        logic   opens;
        logic   closes;
        t_bkind kind;
    } t_char_class;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_char_code = 8'h00;
    logic                   i_last = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_balanced;
    logic [2:0]             o_error_kind;
    logic [COUNT_WIDTH-1:0] o_pair_count;

    // Predictor state.
    t_bkind                 open_kinds [STACK_DEPTH];
    int unsigned            stack_level = 0;
    logic [COUNT_WIDTH-1:0] pair_tally = '0;
    t_err                   first_fault = ERR_NONE;

    t_verdict   verdicts_due [$];
    logic [7:0] string_buf [$];
    int         fault_count = 0;
    logic       calm = 1'b0;
    logic       hold_req = 1'b0;

    t_row directed_rows [25] = '{
        '{CH_ROUND_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_CLOSE,  1'b1, 1'b1, '{1'b1, ERR_NONE, 16'd1}},
        '{CH_ROUND_CLOSE,  1'b1, 1'b1, '{1'b0, ERR_EMPTY_CLOSE, 16'd0}},
        '{CH_SQUARE_OPEN,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ANGLE_CLOSE,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_CLOSE,  1'b1, 1'b1, '{1'b0, ERR_MISMATCH, 16'd0}},
        '{CH_CURLY_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ANGLE_OPEN,   1'b1, 1'b1, '{1'b0, ERR_UNCLOSED, 16'd0}},
        '{CH_ANGLE_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_SQUARE_OPEN,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_CURLY_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_CLOSE,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_CURLY_CLOSE,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_SQUARE_CLOSE, 1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ANGLE_CLOSE,  1'b1, 1'b1, '{1'b1, ERR_NONE, 16'd4}},
        '{8'h00,           1'b1, 1'b1, '{1'b1, ERR_NONE, 16'd0}},
        '{8'hFF,           1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_CLOSE,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_CURLY_CLOSE,  1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_OPEN,   1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_SQUARE_CLOSE, 1'b1, 1'b1, '{1'b0, ERR_EMPTY_CLOSE, 16'd1}},
        '{8'h55,           1'b0, 1'b0, '{1'b0, ERR_NONE, 16'd0}},
        '{CH_ROUND_OPEN,   1'b1, 1'b0, '{1'b0, ERR_NONE, 16'd0}}
    };

    bracket_balance_checker_unit #(
        .STACK_DEPTH(STACK_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_balanced  (o_balanced),
        .o_error_kind(o_error_kind),
        .o_pair_count(o_pair_count)
    );

    always #4 i_clk = ~i_clk;

    // Sort a byte into opening bracket, closing bracket or neither.
    function automatic t_char_class decode_char(input logic [7:0] c);
        t_char_class cc;
        cc = '{opens: 1'b0, closes: 1'b0, kind: BK_ROUND};
        case (c)
            CH_ROUND_OPEN:   cc = '{opens: 1'b1, closes: 1'b0, kind: BK_ROUND};
            CH_CURLY_OPEN:   cc = '{opens: 1'b1, closes: 1'b0, kind: BK_CURLY};
            CH_SQUARE_OPEN:  cc = '{opens: 1'b1, closes: 1'b0, kind: BK_SQUARE};
            CH_ANGLE_OPEN:   cc = '{opens: 1'b1, closes: 1'b0, kind: BK_ANGLE};
            CH_ROUND_CLOSE:  cc = '{opens: 1'b0, closes: 1'b1, kind: BK_ROUND};
            CH_CURLY_CLOSE:  cc = '{opens: 1'b0, closes: 1'b1, kind: BK_CURLY};
            CH_SQUARE_CLOSE: cc = '{opens: 1'b0, closes: 1'b1, kind: BK_SQUARE};
            CH_ANGLE_CLOSE:  cc = '{opens: 1'b0, closes: 1'b1, kind: BK_ANGLE};
            default:         cc = '{opens: 1'b0, closes: 1'b0, kind: BK_ROUND};
        endcase
        return cc;
    endfunction

    // Character for a bracket of the given kind and direction.
    function automatic logic [7:0] bracket_char(input logic opening, input t_bkind k);
        case (k)
            BK_ROUND:  return opening ? CH_ROUND_OPEN : CH_ROUND_CLOSE;
            BK_CURLY:  return opening ? CH_CURLY_OPEN : CH_CURLY_CLOSE;
            BK_SQUARE: return opening ? CH_SQUARE_OPEN : CH_SQUARE_CLOSE;
            default:   return opening ? CH_ANGLE_OPEN : CH_ANGLE_CLOSE;
        endcase
    endfunction

    function automatic t_bkind random_kind();
        return t_bkind'($urandom_range(0, 3));
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Apply one byte to the predicted stack; returns 1 with the verdict on the last byte.
    function automatic logic scan_byte(input logic [7:0] c, input logic l, output t_verdict v);
        t_char_class cc;
        t_err        verdict_err;
        cc = decode_char(c);
        v = '0;
        if (first_fault == ERR_NONE) begin
            if (cc.opens) begin
                if (stack_level >= STACK_DEPTH) begin
                    first_fault = ERR_OVERFLOW;
                end else begin
                    open_kinds[stack_level] = cc.kind;
                    stack_level++;
                end
            end else if (cc.closes) begin
                if (stack_level == 0) begin
                    first_fault = ERR_EMPTY_CLOSE;
                end else if (open_kinds[stack_level-1] != cc.kind) begin
                    first_fault = ERR_MISMATCH;
                end else begin
                    stack_level--;
                    if (pair_tally != '1) pair_tally++;
                end
            end
        end
        if (!l) return 1'b0;
        verdict_err = first_fault;
        if (verdict_err == ERR_NONE && stack_level != 0) verdict_err = ERR_UNCLOSED;
        v.balanced = (verdict_err == ERR_NONE);
        v.kind     = verdict_err;
        v.pairs    = pair_tally;
        // The block starts the next string from an empty stack.
        stack_level = 0;
        pair_tally  = '0;
        first_fault = ERR_NONE;
        return 1'b1;
    endfunction

    // Offer one byte, wait for the transfer, and record the verdict it causes.
    task automatic send_byte(input logic [7:0] c, input logic l, input logic given_ok,
                             input t_verdict given);
        int       gap;
        t_verdict v;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last      <= l;
        do @(posedge i_clk); while (o_in_stall);
        if (scan_byte(c, l, v)) verdicts_due.push_back(given_ok ? given : v);
    endtask

    task automatic send_string();
        foreach (string_buf[n]) begin
            send_byte(string_buf[n], n == string_buf.size() - 1, 1'b0, '0);
        end
    endtask

    // Build a random string: mostly well nested with noise, some left open,
    // some with one byte corrupted, some raw bytes.
    task automatic fill_random_string(input int max_len, input int max_depth);
        t_bkind     kinds [$];
        int         len;
        int         style;
        int         pick;
        logic [7:0] ch;
        string_buf.delete();
        style = $urandom_range(0, 99);
        len   = $urandom_range(1, max_len);
        for (int n = 0; n < len; n++) begin
            pick = $urandom_range(0, 9);
            if (style >= 90) begin
                if (pick < 5) ch = 8'($urandom_range(0, 255));
                else ch = bracket_char(1'($urandom_range(0, 1)), random_kind());
            end else if (pick < 2) begin
                // Non-bracket noise; flipping the top bit moves a bracket out of the set.
                ch = 8'($urandom_range(0, 255));
                if (decode_char(ch).opens || decode_char(ch).closes) ch ^= 8'h80;
            end else if (kinds.size() == 0 || (pick < 6 && kinds.size() < max_depth)) begin
                kinds.push_back(random_kind());
                ch = bracket_char(1'b1, kinds[$]);
            end else begin
                ch = bracket_char(1'b0, kinds.pop_back());
            end
            string_buf.push_back(ch);
        end
        if (style < 75) begin
            while (kinds.size() != 0) string_buf.push_back(bracket_char(1'b0, kinds.pop_back()));
        end
        if (style >= 80 && style < 90) begin
            string_buf[$urandom_range(0, string_buf.size() - 1)] =
                bracket_char(1'($urandom_range(0, 1)), random_kind());
        end
    endtask

    // Stimulus and end of run.
    initial begin : feed_strings
        t_bkind kinds [$];
        int     random_items;
        logic   hold_done;
        random_items = 0;
        hold_done    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings.
        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].ch, directed_rows[r].last, directed_rows[r].given,
                      directed_rows[r].want);
        end

        // Fill the stack to its full depth, then drain it completely.
        string_buf.delete();
        for (int n = 0; n < STACK_DEPTH; n++) begin
            kinds.push_back(random_kind());
            string_buf.push_back(bracket_char(1'b1, kinds[$]));
        end
        while (kinds.size() != 0) string_buf.push_back(bracket_char(1'b0, kinds.pop_back()));
        send_string();

        // A few pairs, then one opening bracket more than the stack holds.
        string_buf.delete();
        repeat (3) begin
            string_buf.push_back(CH_CURLY_OPEN);
            string_buf.push_back(CH_CURLY_CLOSE);
        end
        repeat (STACK_DEPTH + 1) string_buf.push_back(bracket_char(1'b1, random_kind()));
        repeat (4) string_buf.push_back(bracket_char(1'b0, random_kind()));
        send_string();
        string_buf.delete();

        // Random strings, with one long hold-off on the verdict side midway.
        while (random_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (!hold_done && random_items >= RANDOM_ITEMS / 2) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                calm      = 1'b1;
                repeat (8) begin
                    fill_random_string(6, 4);
                    random_items += string_buf.size();
                    send_string();
                end
            end
            fill_random_string(30, $urandom_range(1, 12));
            random_items += string_buf.size();
            send_string();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Verdict side: random stalls, one long hold-off, and checking of each transfer.
    initial begin : take_verdicts
        t_verdict want;
        int       hold;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                hold = draw_gap();
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            if (verdicts_due.size() == 0) begin
                $error("verdict with none pending: balanced %0d error_kind %0d pair_count %0d",
                       o_balanced, o_error_kind, o_pair_count);
                fault_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (o_balanced !== want.balanced) begin
                    $error("balanced: expected %0d, actual %0d", want.balanced, o_balanced);
                    fault_count++;
                end
                if (o_error_kind !== want.kind) begin
                    $error("error_kind: expected %0d, actual %0d", want.kind, o_error_kind);
                    fault_count++;
                end
                if (o_pair_count !== want.pairs) begin
                    $error("pair_count: expected %0d, actual %0d", want.pairs, o_pair_count);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/bbc_pkg.sv
src/bbc_stack.sv
src/bracket_balance_checker_unit.sv
test/tb_top.sv
